// File: hdl/slfr_pkg.sv
// Shared types and constants for the sensor link frame receiver.
package slfr_pkg;

    // Default longest frame accepted, header and checksum included
    localparam int MaxFrameBytesDefault = 34;

    // One-byte link messages and the mode select header
    localparam logic [7:0] SyncByte     = 8'h00;
    localparam logic [7:0] NackByte     = 8'h02;
    localparam logic [7:0] AckByte      = 8'h04;
    localparam logic [7:0] SelectHeader = 8'h43;
    localparam logic [7:0] XorSeed      = 8'hFF;

    // Link phases
    localparam logic [1:0] PhaseOther    = 2'd0;
    localparam logic [1:0] PhaseWaitSync = 2'd1;
    localparam logic [1:0] PhaseWaitAck  = 2'd2;
    localparam logic [1:0] PhaseRunning  = 2'd3;

    // Reported events
    localparam logic [2:0] EvSyncOk      = 3'd0;
    localparam logic [2:0] EvAckOk       = 3'd1;
    localparam logic [2:0] EvNack        = 3'd2;
    localparam logic [2:0] EvSelect      = 3'd3;
    localparam logic [2:0] EvBadNack     = 3'd4;
    localparam logic [2:0] EvIgnored     = 3'd5;
    localparam logic [2:0] EvBadIgnored  = 3'd6;

    // Input request: one received byte and the link phase
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [1:0] link_phase;
    } in_item_t;

    // Output request: event code and selected mode
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] selected_mode;
    } out_item_t;

endpackage

// File: hdl/sensor_link_frame_receiver_core.sv
// Sensor link frame receiver: byte-wise frame parser with checksum and event output.
//
// Each request carries one byte from the host link and the current link phase.
// Between frames a sync, ack or nack byte is a complete message; any other byte
// is a header whose bits 5:3 give a payload of 2^n bytes, followed by one XOR
// checksum byte (seed 0xFF). Headers of frames longer than MAX_FRAME_BYTES are
// dropped. A one-byte message or the checksum byte of a frame yields exactly one
// output request (event code plus selected mode); all other bytes yield none.
// A request is registered on input and then processed into the output
// register, so the block takes one byte per clock unless a finished result finds
// the output register still full; the output register lets the next byte enter
// while a result still waits for out_ready. Output valid rises when the result
// of the registered byte is loaded into the output register.
module sensor_link_frame_receiver_core
#(
    parameter int MAX_FRAME_BYTES = slfr_pkg::MaxFrameBytesDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slfr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output slfr_pkg::out_item_t out_data
);
    import slfr_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_BYTES);

    // Input stage
    logic      in_vld_reg;
    in_item_t  in_item_reg;

    // Frame state
    logic [6:0] frame_length_reg, frame_length_next;
    logic [6:0] byte_index_reg,   byte_index_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic [7:0] header_byte_reg,  header_byte_next;
    logic [7:0] first_payload_reg, first_payload_next;

    // Output stage
    logic      out_vld_reg;
    out_item_t out_item_reg;

    logic      produce;
    out_item_t result;
    logic      advance;

    logic [7:0] b;
    logic [1:0] phase;
    logic [7:0] hdr_len;
    logic       in_frame;
    logic [6:0] cur_index;
    logic [7:0] cur_xor;

    // Decide the event for a completed message
    function automatic out_item_t act(input logic [7:0] hdr, input logic [1:0] ph,
                                      input logic [7:0] fp);
        out_item_t r;
        r.event_res     = EvIgnored;
        r.selected_mode = 8'h00;
        priority if (hdr == NackByte)
        begin
            r.event_res = EvNack;
        end
        else if (ph == PhaseWaitSync && hdr == SyncByte)
        begin
            r.event_res = EvSyncOk;
        end
        else if (ph == PhaseWaitAck && hdr == AckByte)
        begin
            r.event_res = EvAckOk;
        end
        else if (ph == PhaseRunning && hdr == SelectHeader)
        begin
            r.event_res     = EvSelect;
            r.selected_mode = fp;
        end
        else
        begin
            r.event_res = EvIgnored;
        end
        return r;
    endfunction

    assign b     = in_item_reg.rx_byte;
    assign phase = in_item_reg.link_phase;
    assign hdr_len = 8'(8'd1 << b[5:3]) + 8'd2;

    // Parse one byte against the frame state
    always_comb
    begin
        frame_length_next  = frame_length_reg;
        byte_index_next    = byte_index_reg;
        running_xor_next   = running_xor_reg;
        header_byte_next   = header_byte_reg;
        first_payload_next = first_payload_reg;
        produce            = 1'b0;
        result             = '0;
        in_frame           = 1'b0;
        cur_index          = byte_index_reg;
        cur_xor            = running_xor_reg;

        if (frame_length_reg == 7'd0)
        begin
            if (b == SyncByte || b == NackByte || b == AckByte)
            begin
                // one-byte message
                header_byte_next = b;
                produce          = 1'b1;
                result           = act(b, phase, first_payload_reg);
            end
            else if (hdr_len <= MaxLen)
            begin
                // open a new frame
                frame_length_next = hdr_len[6:0];
                cur_index         = 7'd0;
                cur_xor           = XorSeed;
                in_frame          = 1'b1;
            end
        end
        else
        begin
            in_frame = 1'b1;
        end

        if (in_frame)
        begin
            if (cur_index == 7'd0)
            begin
                header_byte_next = b;
            end
            else if (cur_index == 7'd1)
            begin
                first_payload_next = b;
            end
            byte_index_next = cur_index + 7'd1;
            running_xor_next = cur_xor;

            if (byte_index_next >= frame_length_next)
            begin
                // checksum byte closes the frame
                frame_length_next = 7'd0;
                produce           = 1'b1;
                if (cur_xor == b)
                begin
                    result = act(header_byte_next, phase, first_payload_next);
                end
                else if (phase == PhaseRunning)
                begin
                    result.event_res = EvBadNack;
                end
                else
                begin
                    result.event_res = EvBadIgnored;
                end
            end
            else
            begin
                running_xor_next = cur_xor ^ b;
            end
        end
    end

    // Advance the input stage when its result, if any, has room
    assign advance  = in_vld_reg && (!produce || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    // Update frame state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= 7'd0;
            byte_index_reg    <= 7'd0;
            running_xor_reg   <= XorSeed;
            header_byte_reg   <= 8'h00;
            first_payload_reg <= 8'h00;
        end
        else if (advance)
        begin
            frame_length_reg  <= frame_length_next;
            byte_index_reg    <= byte_index_next;
            running_xor_reg   <= running_xor_next;
            header_byte_reg   <= header_byte_next;
            first_payload_reg <= first_payload_next;
        end
    end

    // Load or drop the output request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

endmodule
